// ===== hdl/esl_pkg.sv =====
// Package for the encoder speed low-pass block.
// Holds widths, register codes, reset values and the structs passed between modules.
// Used by every file of the block; depends on nothing.
package esl_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int SCALE_W         = 8;
	localparam int COEF_W          = 16;
	localparam int FRAC_W          = 16;
	localparam int SPEED_W         = 20;
	localparam int FILT_W          = SPEED_W + FRAC_W;
	localparam int APB_ADDR_W      = 4;
	localparam int APB_DATA_W      = 32;

	localparam logic [SPEED_W-1:0] SPEED_MAX  = '1;
	localparam logic [FILT_W-1:0]  FILTER_MAX = '1;

	localparam logic [SCALE_W-1:0] SCALE_RST   = SCALE_W'(30);
	localparam logic [COEF_W-1:0]  COEF_FB_RST = COEF_W'(63511);
	localparam logic [COEF_W-1:0]  COEF_IN_RST = COEF_W'(2027);

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		REG_SPEED_SCALE = 2'd0,
		REG_COEF_FB     = 2'd1,
		REG_COEF_IN     = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [SCALE_W-1:0] speed_scale;
		logic [COEF_W-1:0]  coef_feedback;
		logic [COEF_W-1:0]  coef_input;
	} cfg_t;

	typedef struct packed {
		logic edge_en;
		logic tick_en;
		logic phase_b;
	} step_ctrl_t;

endpackage

// ===== hdl/esl_item_if.sv =====
// Input channel of the encoder speed low-pass block: one edge or tick per transaction.
// Depends on esl_pkg.
interface esl_item_if;
	import esl_pkg::*;

	logic valid;
	logic ready;
	logic operation;
	logic phase_b;

	modport source (output valid, output operation, output phase_b, input ready);
	modport sink (input valid, input operation, input phase_b, output ready);

endinterface

// ===== hdl/esl_result_if.sv =====
// Output channel of the encoder speed low-pass block: one filtered speed per transaction.
// Depends on esl_pkg.
interface esl_result_if;
	import esl_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] filtered_speed;

	modport source (output valid, output filtered_speed, input ready);
	modport sink (input valid, input filtered_speed, output ready);

endinterface

// ===== hdl/esl_regs.sv =====
// APB register file: speed scale and the two filter coefficients.
// Depends on esl_pkg.
module esl_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [esl_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [esl_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [esl_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output esl_pkg::cfg_t                    cfg
);
	import esl_pkg::*;

	cfg_t       cfg_q;
	reg_index_t index;
	logic       wr_en;

	assign index  = reg_index_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_scale   <= SCALE_RST;
			cfg_q.coef_feedback <= COEF_FB_RST;
			cfg_q.coef_input    <= COEF_IN_RST;
		end else if (wr_en) begin
			case (index)
				REG_SPEED_SCALE: cfg_q.speed_scale   <= pwdata[SCALE_W-1:0];
				REG_COEF_FB:     cfg_q.coef_feedback <= pwdata[COEF_W-1:0];
				REG_COEF_IN:     cfg_q.coef_input    <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_SPEED_SCALE: prdata = APB_DATA_W'(cfg_q.speed_scale);
			REG_COEF_FB:     prdata = APB_DATA_W'(cfg_q.coef_feedback);
			REG_COEF_IN:     prdata = APB_DATA_W'(cfg_q.coef_input);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== hdl/esl_counter.sv =====
// Saturating up/down edge counter and the speed sample taken from it on each tick.
// Depends on esl_pkg.
module esl_counter #(
	parameter int COUNT_WIDTH = esl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  esl_pkg::step_ctrl_t           ctrl,
	input  logic [esl_pkg::SCALE_W-1:0]   speed_scale,
	output logic [esl_pkg::SPEED_W-1:0]   speed
);
	import esl_pkg::*;

	localparam int PROD_W = COUNT_WIDTH + SCALE_W;
	localparam int WIDE_W = PROD_W + SPEED_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] mag;
	logic [PROD_W-1:0]      prod;
	logic [WIDE_W-1:0]      prod_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.tick_en) begin
			count_q <= '0;
		end else if (ctrl.edge_en) begin
			if (ctrl.phase_b) begin
				if (count_q != CNT_MIN) begin
					count_q <= count_q - 1'b1;
				end
			end else begin
				if (count_q != CNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign mag       = count_q[COUNT_WIDTH-1] ? (~count_q + 1'b1) : count_q;
	assign prod      = PROD_W'(mag) * PROD_W'(speed_scale);
	assign prod_wide = WIDE_W'(prod);
	assign speed     = (prod_wide > WIDE_W'(SPEED_MAX)) ? SPEED_MAX : prod_wide[SPEED_W-1:0];

endmodule

// ===== hdl/esl_filter.sv =====
// First-order low-pass filter state in unsigned 20.16 fixed point.
// Depends on esl_pkg.
module esl_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_en,
	input  logic [esl_pkg::SPEED_W-1:0]   speed,
	input  esl_pkg::cfg_t                 cfg,
	output logic [esl_pkg::SPEED_W-1:0]   y_int
);
	import esl_pkg::*;

	localparam int FB_PROD_W = COEF_W + FILT_W;

	logic [FILT_W-1:0]    filt_q;
	logic [SPEED_W-1:0]   prev_speed_q;
	logic [FB_PROD_W-1:0] fb_prod;
	logic [FILT_W-1:0]    fb_term;
	logic [FILT_W-1:0]    in_term;
	logic [FILT_W:0]      sum;
	logic [FILT_W-1:0]    y;

	assign fb_prod = FB_PROD_W'(cfg.coef_feedback) * FB_PROD_W'(filt_q);
	assign fb_term = fb_prod[FB_PROD_W-1:FRAC_W];
	assign in_term = FILT_W'(cfg.coef_input) * FILT_W'(prev_speed_q);
	assign sum     = {1'b0, fb_term} + {1'b0, in_term};
	assign y       = sum[FILT_W] ? FILTER_MAX : sum[FILT_W-1:0];
	assign y_int   = y[FILT_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q       <= '0;
			prev_speed_q <= '0;
		end else if (tick_en) begin
			filt_q       <= y;
			prev_speed_q <= speed;
		end
	end

endmodule

// ===== hdl/encoder_speed_lowpass.sv =====
// Top level of the encoder speed low-pass block.
// Depends on esl_pkg, esl_item_if, esl_result_if, esl_regs, esl_counter and esl_filter.
//
// Each transaction on item carries either a rising edge of encoder phase A, with the
// level of phase B, or a sample tick. Edges move a saturating signed count; a tick
// turns the count's magnitude times speed_scale into a speed sample, clears the count,
// steps the low-pass filter and returns one transaction on result with the integer
// part of the filter output. Edges return nothing.
// An accepted item is held in the input register, where all of its work is done, and a
// tick's result is then loaded into the result register. One item is taken every cycle
// unless a tick is held in the input register.
// When result is stalled, edges keep flowing; a tick waits in the input register and
// item.ready drops until the pending result is taken.
// The user must write the registers over the APB port only while the block is idle; the block does not enforce it.
// Reset clears the count, the filter state and both valid flags, and loads the
// register defaults: speed_scale 30, coef_feedback 63511, coef_input 2027.
module encoder_speed_lowpass #(
	parameter int COUNT_WIDTH = esl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	esl_item_if.sink                       item,
	esl_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [esl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [esl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [esl_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import esl_pkg::*;

	cfg_t               cfg;
	step_ctrl_t         ctrl;
	logic               valid_s1;
	logic               op_s1;
	logic               phase_b_s1;
	logic               go_s1;
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_data_q;
	logic [SPEED_W-1:0] speed;
	logic [SPEED_W-1:0] y_int;

	esl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign go_s1 = valid_s1 && ((op_s1 == OP_EDGE) || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1      <= item.operation;
			phase_b_s1 <= item.phase_b;
		end
	end

	assign ctrl.edge_en = go_s1 && (op_s1 == OP_EDGE);
	assign ctrl.tick_en = go_s1 && (op_s1 == OP_TICK);
	assign ctrl.phase_b = phase_b_s1;

	esl_counter #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counter (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.speed_scale (cfg.speed_scale),
		.speed       (speed)
	);

	esl_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_en (ctrl.tick_en),
		.speed   (speed),
		.cfg     (cfg),
		.y_int   (y_int)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.tick_en) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tick_en) begin
			out_data_q <= y_int;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.filtered_speed = out_data_q;

endmodule

// ===== hdl/esl_checker.sv =====
// Port-level checker for the encoder speed low-pass block, bound to the top level.
// Depends on esl_pkg and encoder_speed_lowpass.
module esl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_operation,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [esl_pkg::SPEED_W-1:0]  out_speed,
	input logic                         pready
);
	import esl_pkg::*;

	// A result transaction that waits holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_speed))
		else $error("stalled result changed");

	// With no result pending the input side is never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// A fresh result follows a tick accepted into the input register and carried on to the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (in_operation == OP_TICK), 2))
		else $error("result without a preceding tick");

	// The register port never inserts wait states.
	assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind encoder_speed_lowpass esl_checker u_esl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_operation (item.operation),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_speed    (result.filtered_speed),
	.pready       (pready)
);

// ===== tb/esl_speed_checker.sv =====
// Checker for the encoder speed low-pass block: watches the item, result and APB ports,
// predicts each filtered speed and compares it with what the block returns.
// Depends on esl_pkg, esl_item_if and esl_result_if.
module esl_speed_checker
	import esl_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	esl_item_if                   item,
	esl_result_if                 result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    pending,
	output int                    fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [COUNT_WIDTH-1:0] COUNT_TOP    = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] COUNT_BOTTOM = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	cfg_t                          cfg;
	logic signed [COUNT_WIDTH-1:0] edge_total;
	logic [FILT_W-1:0]             lowpass_acc;
	logic [SPEED_W-1:0]            last_speed;
	logic [SPEED_W-1:0]            speed_expect_q[$];

	always @(posedge clk or negedge arst_n) begin : predict
		logic [COUNT_WIDTH-1:0]         magnitude;
		logic [COUNT_WIDTH+SCALE_W-1:0] scaled;
		logic [SPEED_W-1:0]             speed;
		logic [COEF_W+FILT_W-1:0]       fb_prod;
		logic [FILT_W-1:0]              in_term;
		logic [FILT_W:0]                sum;
		logic [FILT_W-1:0]              filt_next;
		logic [SPEED_W-1:0]             got;
		if (!arst_n) begin
			cfg.speed_scale   = SCALE_RST;
			cfg.coef_feedback = COEF_FB_RST;
			cfg.coef_input    = COEF_IN_RST;
			edge_total  = '0;
			lowpass_acc = '0;
			last_speed  = '0;
			speed_expect_q.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
					REG_SPEED_SCALE: cfg.speed_scale = pwdata[SCALE_W-1:0];
					REG_COEF_FB:     cfg.coef_feedback = pwdata[COEF_W-1:0];
					REG_COEF_IN:     cfg.coef_input = pwdata[COEF_W-1:0];
					default: ;
				endcase
			end

			// The result leaving now always belongs to an older tick than one entering now.
			if (result.valid && result.ready) begin
				got = result.filtered_speed;
				if (speed_expect_q.size() == 0) begin
					$error("filtered_speed: transaction with none expected, actual %0d", got);
					fail_count++;
				end else if (speed_expect_q[0] !== got) begin
					$error("filtered_speed mismatch: expected %0d, actual %0d",
						speed_expect_q[0], got);
					fail_count++;
					void'(speed_expect_q.pop_front());
				end else begin
					void'(speed_expect_q.pop_front());
				end
			end

			if (item.valid && item.ready) begin
				if (item.operation == OP_EDGE) begin
					if (item.phase_b) begin
						if (edge_total != COUNT_BOTTOM)
							edge_total = edge_total - 1'b1;
					end else begin
						if (edge_total != COUNT_TOP)
							edge_total = edge_total + 1'b1;
					end
				end else begin
					magnitude = edge_total[COUNT_WIDTH-1] ? -edge_total : edge_total;
					scaled = magnitude * cfg.speed_scale;
					speed = (scaled > SPEED_MAX) ? SPEED_MAX : SPEED_W'(scaled);
					edge_total = '0;
					fb_prod = cfg.coef_feedback * lowpass_acc;
					in_term = cfg.coef_input * last_speed;
					sum = fb_prod[COEF_W+FILT_W-1:FRAC_W] + in_term;
					filt_next = (sum > FILTER_MAX) ? FILTER_MAX : sum[FILT_W-1:0];
					lowpass_acc = filt_next;
					last_speed = speed;
					speed_expect_q.push_back(filt_next[FILT_W-1:FRAC_W]);
				end
			end
		end
		pending = speed_expect_q.size();
	end

endmodule

// ===== tb/tb.sv =====
// Top of the encoder speed low-pass testbench: clock, reset, APB register writes and
// randomly paced edge and tick transactions; the verdict comes from esl_speed_checker.
// Depends on esl_pkg, esl_item_if, esl_result_if, esl_speed_checker and the block.
module tb;
	import esl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    pending;
	int                    fail_count;
	int                    idle_cycles = 0;
	logic                  quiet = 1'b0;

	esl_item_if   item_ch();
	esl_result_if result_ch();

	encoder_speed_lowpass #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	esl_speed_checker #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) speed_check (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.pending(pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_sink
		int   stall;
		logic taken;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = result_ch.valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	task automatic send_item(input logic op, input logic pb);
		int   gap;
		logic taken;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.phase_b   <= pb;
		do begin
			@(negedge clk);
			taken = item_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits are random so that the register width masking is exercised.
	task automatic cfg_phase(input logic [SCALE_W-1:0] scale, input logic [COEF_W-1:0] fb,
		input logic [COEF_W-1:0] gain);
		logic [APB_DATA_W-1:0] junk;
		junk = $urandom();
		reg_write(REG_SPEED_SCALE, {junk[APB_DATA_W-1:SCALE_W], scale});
		junk = $urandom();
		reg_write(REG_COEF_FB, {junk[APB_DATA_W-1:COEF_W], fb});
		junk = $urandom();
		reg_write(REG_COEF_IN, {junk[APB_DATA_W-1:COEF_W], gain});
		reg_write(REG_UNUSED, $urandom());
	endtask

	task automatic random_run(input int n);
		int down_pct;
		down_pct = $urandom_range(0, 100);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_item(OP_TICK, 1'($urandom()));
				down_pct = $urandom_range(0, 100);
			end else begin
				send_item(OP_EDGE, $urandom_range(0, 99) < down_pct);
			end
		end
	endtask

	initial begin
		item_ch.valid     <= 1'b0;
		item_ch.operation <= OP_EDGE;
		item_ch.phase_b   <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		arst_n  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_TICK, 1'b0);
		repeat (3) send_item(OP_EDGE, 1'b0);
		send_item(OP_TICK, 1'b1);
		repeat (5) send_item(OP_EDGE, 1'b1);
		send_item(OP_TICK, 1'b0);
		send_item(OP_EDGE, 1'b0);
		send_item(OP_EDGE, 1'b1);
		send_item(OP_TICK, 1'b1);
		send_item(OP_TICK, 1'b0);
		drain();

		// Long one-way bursts in both directions with every register at its maximum.
		quiet = 1'b1;
		cfg_phase(8'd255, 16'hFFFF, 16'hFFFF);
		repeat (150) send_item(OP_EDGE, 1'b0);
		send_item(OP_TICK, 1'b0);
		repeat (150) send_item(OP_EDGE, 1'b1);
		send_item(OP_TICK, 1'b1);
		send_item(OP_TICK, 1'b0);
		send_item(OP_TICK, 1'b1);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			quiet = (phase == 2);
			case (phase)
				0: begin
					cfg_phase('0, '0, '0);
				end
				1: begin
					cfg_phase('1, '1, '1);
				end
				2: begin
					cfg_phase(SCALE_RST, COEF_FB_RST, COEF_IN_RST);
				end
				4: begin
					cfg_phase(8'd1, 16'h8000, 16'h8000);
				end
				default: begin
					cfg_phase(SCALE_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()));
				end
			endcase
			random_run(205);
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
